/* src/lrp_pkg.sv */
package lrp_pkg;

  // default pool geometry
  localparam int unsigned PoolDepthDef = 16;
  localparam logic [4:0]  PoolLimitRst = 5'd16;

  // input operations
  typedef enum logic [1:0] {
    OP_REUSE = 2'd0,
    OP_ADD   = 2'd1,
    OP_CLEAN = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // result kinds
  typedef enum logic [2:0] {
    K_EXACT   = 3'd0,
    K_RESIZED = 3'd1,
    K_MISS    = 3'd2,
    K_ADDED   = 3'd3,
    K_REPLACE = 3'd4,
    K_SKIP    = 3'd5,
    K_EVICT   = 3'd6,
    K_DONE    = 3'd7
  } kind_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXACT,
    S_RESIZE,
    S_ADD,
    S_REPL,
    S_CNT,
    S_EVICT
  } state_t;

  // one pool entry as held in the memory
  typedef struct packed {
    logic [63:0] hash;
    logic [31:0] prims;
    logic [31:0] frame;
    logic [31:0] handle;
    logic [39:0] size;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // one result beat
  typedef struct packed {
    kind_t       kind;
    logic [3:0]  slot;
    logic [31:0] handle_out;
    logic [39:0] size_out;
    logic [43:0] freed_total;
    logic [4:0]  entries_left;
    logic [7:0]  used_count;
    logic        last;
  } res_t;

endpackage

/* src/lrp_if.sv */
interface lrp_in_if import lrp_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] geometry_hash;
  logic [31:0] prim_count;
  logic [31:0] frame;
  logic [31:0] handle_id;
  logic [39:0] size_bytes;
  logic [31:0] max_age;

  modport source (output valid, op, geometry_hash, prim_count, frame, handle_id,
                  size_bytes, max_age, input ready);
  modport sink (input valid, op, geometry_hash, prim_count, frame, handle_id,
                size_bytes, max_age, output ready);
endinterface

interface lrp_out_if import lrp_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  slot;
  logic [31:0] handle_out;
  logic [39:0] size_out;
  logic [43:0] freed_total;
  logic [4:0]  entries_left;
  logic [7:0]  used_count;
  logic        last;

  modport source (output valid, kind, slot, handle_out, size_out, freed_total,
                  entries_left, used_count, last, input ready);
  modport sink (input valid, kind, slot, handle_out, size_out, freed_total,
                entries_left, used_count, last, output ready);
endinterface

/* src/lrp_ram.sv */
module lrp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/lru_reuse_pool_table_unit.sv */
// Pool of reusable objects kept in one entry memory, in insertion order.
// in_ch carries one request beat (reuse lookup, add or age cleanup); out_ch
// returns result beats, the final one of a request marked by last. cfg_we
// with cfg_wdata sets the pool limit; the user is to write it only while the unit
// is idle, which the block itself does not enforce. A request is taken only in
// idle; the sequencer reads one entry per cycle from the memory (one read port,
// registered read) unless a stalled result holds the scan. A reuse lookup tries
// an exact pass, then a resize pass; an add appends while there is room, else
// scans for the oldest free entry; a cleanup counts survivors, then evicts, each
// evicted entry giving its beat on the way. A result sits in the output register
// until taken; the next request is accepted meanwhile. When the receiver stalls
// with a second beat pending, the scan holds where that beat is made. Reset
// empties the pool, clears the reuse counter, sets the limit to 16 and drops any
// pending beat; the memory needs no clearing as only held entries are read.
module lru_reuse_pool_table_unit import lrp_pkg::*; #(
  parameter int unsigned POOL_DEPTH = PoolDepthDef
) (
  input  logic       clk,
  input  logic       rst_n,
  lrp_in_if.sink     in_ch,
  lrp_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata
);

  localparam int unsigned IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned CW = $clog2(POOL_DEPTH + 1);
  localparam logic [6:0]  DepthC = 7'(POOL_DEPTH);

  state_t         state_r, state_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [7:0]     reuse_r, reuse_nxt;
  logic [4:0]     lim_r;
  logic [POOL_DEPTH-1:0] busy_r, busy_nxt;
  logic [CW-1:0]  keep_r, keep_nxt;
  logic [CW-1:0]  keep_tot_r, keep_tot_nxt;
  logic [43:0]    freed_r, freed_nxt;
  logic [31:0]    oldest_r, oldest_nxt;
  logic           found_r, found_nxt;
  logic [CW-1:0]  pick_r, pick_nxt;
  logic [31:0]    pick_handle_r, pick_handle_nxt;
  logic [39:0]    pick_size_r, pick_size_nxt;
  res_t           out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;

  // request held for the duration of the operation
  entry_t      req_r;
  logic [31:0] max_age_r;

  logic        mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t      mem_wdata;
  entry_t      rd;
  logic        in_fire;
  logic        out_free;
  logic        in_range;
  logic        rd_busy;
  logic        full;
  logic [31:0] age;
  logic        evict;

  lrp_ram #(.WIDTH(EntryW), .DEPTH(POOL_DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx_nxt[IW-1:0]),
    .rdata (rd)
  );

  function automatic res_t mk_res(kind_t k, logic [CW-1:0] slot, logic [31:0] h,
                                  logic [39:0] s, logic [43:0] f, logic [CW-1:0] left,
                                  logic [7:0] used, logic lst);
    res_t r;
    r.kind         = k;
    r.slot         = 4'(slot);
    r.handle_out   = h;
    r.size_out     = s;
    r.freed_total  = f;
    r.entries_left = 5'(left);
    r.used_count   = used;
    r.last         = lst;
    return r;
  endfunction

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_range = idx_r < cnt_r;
  assign rd_busy  = busy_r[idx_r[IW-1:0]];
  assign full     = (7'(cnt_r) >= 7'(lim_r)) || (7'(cnt_r) >= DepthC);
  assign age      = req_r.frame - rd.frame;
  assign evict    = !rd_busy && (age > max_age_r);

  // sequencer: next state, memory writes and result beats
  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    cnt_nxt         = cnt_r;
    reuse_nxt       = reuse_r;
    busy_nxt        = busy_r;
    keep_nxt        = keep_r;
    keep_tot_nxt    = keep_tot_r;
    freed_nxt       = freed_r;
    oldest_nxt      = oldest_r;
    found_nxt       = found_r;
    pick_nxt        = pick_r;
    pick_handle_nxt = pick_handle_r;
    pick_size_nxt   = pick_size_r;
    out_nxt         = out_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    mem_we          = 1'b0;
    mem_waddr       = idx_r[IW-1:0];
    mem_wdata       = rd;
    unique case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (in_fire) begin
          unique case (op_t'(in_ch.op))
            OP_REUSE: state_nxt = S_EXACT;
            OP_ADD: begin
              oldest_nxt = in_ch.frame;
              found_nxt  = 1'b0;
              pick_nxt   = '0;
              state_nxt  = full ? S_REPL : S_ADD;
            end
            OP_CLEAN: begin
              keep_nxt  = '0;
              state_nxt = S_CNT;
            end
            OP_NONE: state_nxt = S_IDLE;
          endcase
        end
      end
      // first pass: exact hash and count among free entries
      S_EXACT: begin
        if (!in_range) begin
          idx_nxt   = '0;
          state_nxt = S_RESIZE;
        end else if (!rd_busy && rd.hash == req_r.hash && rd.prims == req_r.prims) begin
          if (out_free) begin
            mem_we          = 1'b1;
            mem_wdata.frame = req_r.frame;
            busy_nxt[idx_r[IW-1:0]] = 1'b1;
            reuse_nxt       = (reuse_r == 8'hFF) ? reuse_r : reuse_r + 8'd1;
            out_nxt         = mk_res(K_EXACT, idx_r, rd.handle, rd.size, '0, cnt_r,
                                     reuse_nxt, 1'b1);
            out_valid_nxt   = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      // second pass: first free entry with req <= count < 1.5 req
      S_RESIZE: begin
        if (!in_range) begin
          if (out_free) begin
            out_nxt       = mk_res(K_MISS, '0, '0, '0, '0, cnt_r, reuse_r, 1'b1);
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (!rd_busy && rd.prims >= req_r.prims &&
                     ({1'b0, rd.prims, 1'b0} <
                      34'(req_r.prims) + {1'b0, req_r.prims, 1'b0})) begin
          if (out_free) begin
            mem_we          = 1'b1;
            mem_wdata.frame = req_r.frame;
            mem_wdata.hash  = req_r.hash;
            mem_wdata.prims = req_r.prims;
            busy_nxt[idx_r[IW-1:0]] = 1'b1;
            reuse_nxt       = (reuse_r == 8'hFF) ? reuse_r : reuse_r + 8'd1;
            out_nxt         = mk_res(K_RESIZED, idx_r, rd.handle, rd.size, '0, cnt_r,
                                     reuse_nxt, 1'b1);
            out_valid_nxt   = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      // append behind the last entry
      S_ADD: begin
        if (out_free) begin
          mem_we        = 1'b1;
          mem_waddr     = cnt_r[IW-1:0];
          mem_wdata     = req_r;
          busy_nxt[cnt_r[IW-1:0]] = 1'b0;
          cnt_nxt       = cnt_r + 1'b1;
          out_nxt       = mk_res(K_ADDED, cnt_r, '0, '0, '0, cnt_nxt, reuse_r, 1'b1);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      // pool full: oldest free entry strictly older than the current frame
      S_REPL: begin
        if (in_range) begin
          if (!rd_busy && rd.frame < oldest_r) begin
            oldest_nxt      = rd.frame;
            found_nxt       = 1'b1;
            pick_nxt        = idx_r;
            pick_handle_nxt = rd.handle;
            pick_size_nxt   = rd.size;
          end
          idx_nxt = idx_r + 1'b1;
        end else if (out_free) begin
          if (found_r) begin
            mem_we    = 1'b1;
            mem_waddr = pick_r[IW-1:0];
            mem_wdata = req_r;
            busy_nxt[pick_r[IW-1:0]] = 1'b0;
            out_nxt   = mk_res(K_REPLACE, pick_r, pick_handle_r, pick_size_r, '0, cnt_r,
                               reuse_r, 1'b1);
          end else begin
            out_nxt   = mk_res(K_SKIP, '0, '0, '0, '0, cnt_r, reuse_r, 1'b1);
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      // cleanup pass one: count survivors
      S_CNT: begin
        if (in_range) begin
          if (!evict) begin
            keep_nxt = keep_r + 1'b1;
          end
          idx_nxt = idx_r + 1'b1;
        end else begin
          keep_tot_nxt = keep_r;
          keep_nxt     = '0;
          freed_nxt    = '0;
          idx_nxt      = '0;
          state_nxt    = S_EVICT;
        end
      end
      // cleanup pass two: report evictions, compact survivors downwards
      S_EVICT: begin
        if (in_range) begin
          if (evict) begin
            if (out_free) begin
              freed_nxt     = freed_r + 44'(rd.size);
              out_nxt       = mk_res(K_EVICT, idx_r, rd.handle, rd.size, freed_nxt,
                                     keep_tot_r, '0, 1'b0);
              out_valid_nxt = 1'b1;
              idx_nxt       = idx_r + 1'b1;
            end
          end else begin
            if (keep_r != idx_r) begin
              mem_we    = 1'b1;
              mem_waddr = keep_r[IW-1:0];
            end
            keep_nxt = keep_r + 1'b1;
            idx_nxt  = idx_r + 1'b1;
          end
        end else if (out_free) begin
          out_nxt       = mk_res(K_DONE, '0, '0, '0, freed_r, keep_tot_r, '0, 1'b1);
          out_valid_nxt = 1'b1;
          cnt_nxt       = keep_tot_r;
          reuse_nxt     = '0;
          busy_nxt      = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      reuse_r     <= '0;
      lim_r       <= PoolLimitRst;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      reuse_r     <= reuse_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        lim_r <= cfg_wdata;
      end
    end
  end

  // scan and payload registers
  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    busy_r        <= busy_nxt;
    keep_r        <= keep_nxt;
    keep_tot_r    <= keep_tot_nxt;
    freed_r       <= freed_nxt;
    oldest_r      <= oldest_nxt;
    found_r       <= found_nxt;
    pick_r        <= pick_nxt;
    pick_handle_r <= pick_handle_nxt;
    pick_size_r   <= pick_size_nxt;
    out_r         <= out_nxt;
    if (in_fire) begin
      req_r.hash   <= in_ch.geometry_hash;
      req_r.prims  <= in_ch.prim_count;
      req_r.frame  <= in_ch.frame;
      req_r.handle <= in_ch.handle_id;
      req_r.size   <= in_ch.size_bytes;
      max_age_r    <= in_ch.max_age;
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_r.kind;
  assign out_ch.slot         = out_r.slot;
  assign out_ch.handle_out   = out_r.handle_out;
  assign out_ch.size_out     = out_r.size_out;
  assign out_ch.freed_total  = out_r.freed_total;
  assign out_ch.entries_left = out_r.entries_left;
  assign out_ch.used_count   = out_r.used_count;
  assign out_ch.last         = out_r.last;

endmodule

/* src/lrp_chk.sv */
module lrp_chk import lrp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  kind,
  input logic [3:0]  slot,
  input logic [31:0] handle_out,
  input logic [43:0] freed_total,
  input logic        last
);

  // nothing pending right after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid after reset");

  // a stalled beat holds its kind
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(kind))
    else $error("stalled result changed");

  // miss and skip carry no slot and no handle
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (kind == K_MISS || kind == K_SKIP) |-> slot == '0 && handle_out == '0)
    else $error("miss or skip with slot or handle");

  // freed total only within a cleanup
  a_freed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind != K_EVICT && kind != K_DONE |-> freed_total == '0)
    else $error("freed total outside cleanup");

  // evictions are never final, everything else is
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (last == (kind != K_EVICT)))
    else $error("last mark wrong");

endmodule

bind lru_reuse_pool_table_unit lrp_chk u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .kind        (out_ch.kind),
  .slot        (out_ch.slot),
  .handle_out  (out_ch.handle_out),
  .freed_total (out_ch.freed_total),
  .last        (out_ch.last)
);

/* tb/sv/lru_reuse_pool_table_unit_tb.sv */
module lru_reuse_pool_table_unit_tb import lrp_pkg::*; ();

  localparam int unsigned Depth    = 16;
  localparam int unsigned Deadline = 400000;

  typedef struct {
    op_t         op;
    logic [63:0] hash;
    logic [31:0] prims;
    logic [31:0] frame;
    logic [31:0] handle;
    logic [39:0] size;
    logic [31:0] max_age;
  } request_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [4:0] cfg_wdata;

  lrp_in_if  in_ch ();
  lrp_out_if out_ch ();

  lru_reuse_pool_table_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // shadow of the pool
  logic [63:0] pool_hash [Depth];
  logic [31:0] pool_prims [Depth];
  logic [31:0] pool_frame [Depth];
  logic [31:0] pool_handle [Depth];
  logic [39:0] pool_size [Depth];
  logic        pool_busy [Depth];
  int unsigned pool_count;
  int unsigned reuse_tally;
  int unsigned pool_limit;

  request_t pending_reqs[$];
  res_t     expected_beats[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap;
  int unsigned recv_gap;
  bit          stall_phase;
  bit          stall_long;
  bit          stim_done;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void put_beat(res_t b);
    expected_beats.insert(expected_beats.size(), b);
  endfunction

  function automatic void put_req(request_t q);
    pending_reqs.insert(pending_reqs.size(), q);
  endfunction

  function automatic res_t mk_beat(kind_t k, int unsigned slot, logic [31:0] h,
                                   logic [39:0] s, logic [43:0] f, int unsigned left,
                                   int unsigned used, bit last);
    res_t r;
    r.kind = k;
    r.slot = slot[3:0];
    r.handle_out = h;
    r.size_out = s;
    r.freed_total = f;
    r.entries_left = left[4:0];
    r.used_count = used[7:0];
    r.last = last;
    return r;
  endfunction

  function automatic void mark_taken(int unsigned i, logic [31:0] frame);
    pool_busy[i] = 1'b1;
    pool_frame[i] = frame;
    if (reuse_tally < 255) reuse_tally++;
  endfunction

  // works out the result beats for one request and updates the shadow pool
  function automatic void predict_pool(request_t q);
    int unsigned n;
    int unsigned lim;
    int unsigned keep;
    int unsigned pick;
    logic [31:0] oldest;
    logic [31:0] age;
    logic [43:0] freed;
    logic [63:0] c2;
    logic [63:0] r3;
    bit found;
    res_t evicted[$];
    n = pool_count;
    found = 0;
    case (q.op)
      OP_REUSE: begin
        for (int i = 0; i < n && !found; i++)
          if (!pool_busy[i] && pool_hash[i] == q.hash && pool_prims[i] == q.prims) begin
            mark_taken(i, q.frame);
            put_beat(mk_beat(K_EXACT, i, pool_handle[i], pool_size[i],
                             0, n, reuse_tally, 1));
            found = 1;
          end
        for (int i = 0; i < n && !found; i++) begin
          c2 = 64'(pool_prims[i]) * 2;
          r3 = 64'(q.prims) * 3;
          if (!pool_busy[i] && pool_prims[i] >= q.prims && c2 < r3) begin
            mark_taken(i, q.frame);
            pool_hash[i] = q.hash;
            pool_prims[i] = q.prims;
            put_beat(mk_beat(K_RESIZED, i, pool_handle[i], pool_size[i],
                             0, n, reuse_tally, 1));
            found = 1;
          end
        end
        if (!found) put_beat(mk_beat(K_MISS, 0, 0, 0, 0, n, reuse_tally, 1));
      end
      OP_ADD: begin
        lim = (pool_limit > Depth) ? Depth : pool_limit;
        pick = n;
        if (n >= lim) begin
          oldest = q.frame;
          for (int i = 0; i < n; i++)
            if (!pool_busy[i] && pool_frame[i] < oldest) begin
              oldest = pool_frame[i];
              pick = i;
              found = 1;
            end
          if (!found) begin
            put_beat(mk_beat(K_SKIP, 0, 0, 0, 0, n, reuse_tally, 1));
            return;
          end
          put_beat(mk_beat(K_REPLACE, pick, pool_handle[pick],
                           pool_size[pick], 0, n, reuse_tally, 1));
        end else begin
          pool_count = n + 1;
          put_beat(mk_beat(K_ADDED, pick, 0, 0, 0, pool_count, reuse_tally, 1));
        end
        pool_hash[pick] = q.hash;
        pool_prims[pick] = q.prims;
        pool_frame[pick] = q.frame;
        pool_handle[pick] = q.handle;
        pool_size[pick] = q.size;
        pool_busy[pick] = 1'b0;
      end
      OP_CLEAN: begin
        keep = 0;
        freed = '0;
        for (int i = 0; i < n; i++) begin
          age = q.frame - pool_frame[i];
          if (!pool_busy[i] && age > q.max_age) begin
            freed += 44'(pool_size[i]);
            evicted.insert(evicted.size(), mk_beat(K_EVICT, i, pool_handle[i],
                                                   pool_size[i], freed, 0, 0, 0));
          end else begin
            pool_hash[keep] = pool_hash[i];
            pool_prims[keep] = pool_prims[i];
            pool_frame[keep] = pool_frame[i];
            pool_handle[keep] = pool_handle[i];
            pool_size[keep] = pool_size[i];
            keep++;
          end
        end
        pool_count = keep;
        reuse_tally = 0;
        for (int j = 0; j < Depth; j++) pool_busy[j] = 1'b0;
        foreach (evicted[j]) begin
          evicted[j].entries_left = keep[4:0];
          put_beat(evicted[j]);
        end
        put_beat(mk_beat(K_DONE, 0, 0, 0, freed, keep, 0, 1));
      end
      default: ;
    endcase
  endfunction

  // hashes mostly come from a small set so that exact hits happen
  function automatic logic [63:0] pick_hash();
    case ($urandom_range(0, 4))
      0: return 64'd0;
      1: return '1;
      2: return {$urandom, $urandom};
      default: return 64'(($urandom_range(0, 3) * 64'h0123_4567_89ab_cdef));
    endcase
  endfunction

  function automatic logic [31:0] pick_prims();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return '1;
      2: return $urandom;
      default: return 32'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic request_t rand_req(logic [31:0] frame);
    request_t q;
    int unsigned r;
    r = $urandom_range(0, 99);
    q.op = (r < 45) ? OP_REUSE : (r < 80) ? OP_ADD : (r < 95) ? OP_CLEAN : OP_NONE;
    q.hash = pick_hash();
    q.prims = pick_prims();
    q.frame = frame;
    q.handle = $urandom;
    q.size = {8'($urandom), 32'($urandom)};
    q.max_age = ($urandom_range(0, 5) == 0) ? 32'($urandom) : 32'($urandom_range(0, 6));
    return q;
  endfunction

  function automatic request_t dir_req(op_t op, logic [63:0] h, logic [31:0] p,
                                       logic [31:0] f, logic [39:0] s,
                                       logic [31:0] age);
    request_t q;
    q.op = op;
    q.hash = h;
    q.prims = p;
    q.frame = f;
    q.handle = $urandom;
    q.size = s;
    q.max_age = age;
    return q;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_beats.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_limit(int unsigned v);
    cfg_we <= 1'b1;
    cfg_wdata <= v[4:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    pool_limit = v;
  endtask

  task automatic run_phase(int unsigned items, logic [31:0] start);
    logic [31:0] f;
    f = start;
    for (int k = 0; k < items; k++) begin
      if ($urandom_range(0, 3) == 0) f = f + 1;
      put_req(rand_req(f));
    end
  endtask

  // stimulus
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    stim_done = 0;
    stall_phase = 0;
    pool_count = 0;
    reuse_tally = 0;
    pool_limit = 16;
    for (int i = 0; i < Depth; i++) pool_busy[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: fill, hits, resize, zero count, wrap on cleanup
    put_req(dir_req(OP_REUSE, '1, '1, 32'd5, 0, 0));
    put_req(dir_req(OP_ADD, '1, '1, 32'd5, '1, 0));
    put_req(dir_req(OP_ADD, 64'd0, 32'd0, 32'd0, 40'd1, 0));
    put_req(dir_req(OP_ADD, 64'd7, 32'd10, 32'd3, 40'd100, 0));
    put_req(dir_req(OP_REUSE, 64'd0, 32'd0, 32'd6, 0, 0));
    put_req(dir_req(OP_REUSE, 64'd9, 32'd7, 32'd6, 0, 0));
    put_req(dir_req(OP_REUSE, 64'd9, 32'd0, 32'd6, 0, 0));
    put_req(dir_req(OP_REUSE, '1, '1, 32'd6, 0, 0));
    put_req(dir_req(OP_REUSE, 64'd9, 32'd6, 32'd6, 0, 0));
    put_req(dir_req(OP_NONE, '1, '1, '1, '1, '1));
    put_req(dir_req(OP_CLEAN, 0, 0, 32'd7, 0, 32'd0));
    put_req(dir_req(OP_ADD, 64'd3, 32'd20, 32'hffff_fff0, '1, 0));
    put_req(dir_req(OP_CLEAN, 0, 0, 32'd2, 0, 32'd4));
    put_req(dir_req(OP_CLEAN, 0, 0, '1, 0, '1));
    wait_drained();

    // limit zero: only replace or skip
    set_limit(0);
    put_req(dir_req(OP_ADD, 64'd1, 32'd1, 32'd4, 40'd9, 0));
    put_req(dir_req(OP_ADD, 64'd1, 32'd1, 32'd100, 40'd9, 0));
    put_req(dir_req(OP_ADD, 64'd1, 32'd1, 32'd0, 40'd9, 0));
    wait_drained();

    // limit above depth acts as depth; fill with long receiver hold-off
    set_limit(31);
    stall_phase = 1;
    run_phase(30, 32'd200);
    wait_drained();

    set_limit(1);
    run_phase(20, 32'd400);
    wait_drained();

    set_limit(3);
    run_phase(20, 32'hffff_fff8);
    wait_drained();

    set_limit(16);
    run_phase(25, 32'd50);
    wait_drained();
    stim_done = 1;
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (stall_phase);
    @(posedge clk);
    stall_long <= 1'b1;
    repeat (300) @(posedge clk);
    stall_long <= 1'b0;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.op <= OP_NONE;
      in_ch.geometry_hash <= '0;
      in_ch.prim_count <= '0;
      in_ch.frame <= '0;
      in_ch.handle_id <= '0;
      in_ch.size_bytes <= '0;
      in_ch.max_age <= '0;
      send_gap <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) predict_pool(pending_reqs.pop_front());
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        request_t q;
        q = pending_reqs[0];
        in_ch.valid <= 1'b1;
        in_ch.op <= q.op;
        in_ch.geometry_hash <= q.hash;
        in_ch.prim_count <= q.prims;
        in_ch.frame <= q.frame;
        in_ch.handle_id <= q.handle;
        in_ch.size_bytes <= q.size;
        in_ch.max_age <= q.max_age;
        send_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat kind %0d", out_ch.kind);
        end else begin
          res_t e;
          e = expected_beats.pop_front();
          if (out_ch.kind !== e.kind || out_ch.slot !== e.slot ||
              out_ch.handle_out !== e.handle_out || out_ch.size_out !== e.size_out ||
              out_ch.freed_total !== e.freed_total ||
              out_ch.entries_left !== e.entries_left ||
              out_ch.used_count !== e.used_count || out_ch.last !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("beat exp %0d/%0d/%h/%h/%h/%0d/%0d/%0d got %0d/%0d/%h/%h/%h/%0d/%0d/%0d",
                       e.kind, e.slot, e.handle_out, e.size_out, e.freed_total,
                       e.entries_left, e.used_count, e.last,
                       out_ch.kind, out_ch.slot, out_ch.handle_out, out_ch.size_out,
                       out_ch.freed_total, out_ch.entries_left, out_ch.used_count,
                       out_ch.last);
          end
        end
      end
      // receiver pacing: a drawn wait after every beat taken
      if (stall_long) begin
        out_ch.ready <= 1'b0;
      end else if (out_ch.valid && out_ch.ready) begin
        int unsigned g;
        g = $urandom_range(0, 10);
        recv_gap <= g;
        out_ch.ready <= (g == 0);
      end else if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        out_ch.ready <= (recv_gap == 1);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // end of run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (stim_done) begin
      if (mismatches == 0) $display("lru_reuse_pool_table_unit regression: pass");
      else $display("lru_reuse_pool_table_unit regression: fail");
      $finish;
    end else if (cycle_count > Deadline) begin
      $display("lru_reuse_pool_table_unit regression: fail");
      $finish;
    end
  end

endmodule
